// File: hdl/idea_block_cipher_defines.svh
// ============================================================================
// IDEA block cipher assertion macros
// Concurrent assertion helpers shared by the cipher RTL.
// ============================================================================
`ifndef IDEA_BLOCK_CIPHER_DEFINES_SVH
`define IDEA_BLOCK_CIPHER_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define IDEA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define IDEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IDEA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IDEA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/idea_pkg.sv
// ============================================================================
// IDEA cipher package
// Stage payload type, schedule constants and word arithmetic helpers.
// ============================================================================
package idea_pkg;

  localparam int NKeys    = 52;
  localparam int NRounds  = 8;
  localparam int NStages  = 3 * NRounds + 1;
  localparam int NInv     = 18;
  localparam int InvSteps = 32;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow  = 2'd1;

  typedef struct packed {
    logic [15:0] x1;
    logic [15:0] x2;
    logic [15:0] x3;
    logic [15:0] x4;
    logic [15:0] t;
  } stg_t;

  // Multiplication modulo 65537, where the word 0 stands for 65536.
  function automatic logic [15:0] mul_mod(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] p;
    logic [15:0] lo;
    logic [15:0] hi;
    p  = 32'(a) * 32'(b);
    lo = p[15:0];
    hi = p[31:16];
    if (a == 16'd0) begin
      mul_mod = 16'd1 - b;
    end else if (b == 16'd0) begin
      mul_mod = 16'd1 - a;
    end else begin
      mul_mod = lo - hi + 16'(lo < hi);
    end
  endfunction

  // Forward subkey i: word (i mod 8) of the key rotated left by 25 bits per group of eight.
  function automatic logic [15:0] fwd_sub(input logic [127:0] k, input int i);
    int s;
    int p;
    logic [127:0] rot;
    s   = (25 * (i / 8)) % 128;
    p   = i % 8;
    rot = (k << s) | ((s == 0) ? 128'd0 : (k >> (128 - s)));
    fwd_sub = rot[127 - 16 * p -: 16];
  endfunction

endpackage

// File: hdl/idea_block_cipher.sv
// ============================================================================
// IDEA block cipher
// 64-bit block, 128-bit key, pipelined rounds with an inverse key sequencer.
// ============================================================================
//
//  Channel  | Direction | Contents
//  ---------+-----------+---------------------------------------------------
//  in_      | slave     | tdata = text_in[63:0], tuser = req_type
//  out_     | master    | tdata = text_out[63:0]
//  cfg_     | write     | index 0 key_high, index 1 key_low, others ignored
//
//  A request runs through 25 register stages: three per round (the two outer
//  multiplications, the first MA multiplication, the second MA multiplication
//  with the mixing) and one for the output transform, and a new request may
//  enter every cycle unless back-pressure reaches stage 0 or the sequencer is busy.
//  Each key write restarts the inverse key sequencer, a single modular
//  multiplier that raises 18 subkeys to the power 65535 one after another;
//  in_tready stays low while it runs. Reset clears keys and control state only.
//  A stalled output back-pressures stage by stage; empty stages still fill.
//
`include "idea_block_cipher_defines.svh"

module idea_block_cipher
  import idea_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] text_in
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] text_out
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // Key registers; the forward schedule is pure wiring from them.
  logic [63:0] key_high_r;
  logic [63:0] key_low_r;
  logic [15:0] fwd [NKeys];
  logic [15:0] dec [NKeys];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegKeyHigh) key_high_r <= cfg_wdata;
      if (cfg_index == RegKeyLow)  key_low_r  <= cfg_wdata;
    end
  end

  for (genvar i = 0; i < NKeys; i++) begin : g_fwd
    assign fwd[i] = fwd_sub({key_high_r, key_low_r}, i);
  end

  // Inverse sequencer. Entry 2j holds inv(fwd[6j]), entry 2j+1 holds inv(fwd[6j+3]).
  logic        inv_busy_r;
  logic        inv_load_r;
  logic [4:0]  inv_idx_r;
  logic [4:0]  inv_step_r;
  logic [15:0] acc_r;
  logic [15:0] base_r;
  logic [15:0] inv_r [NInv];
  logic [15:0] inv_src [NInv];
  logic [15:0] mul_a;
  logic [15:0] mul_res;
  logic        key_wr;

  for (genvar j = 0; j < NInv; j++) begin : g_src
    assign inv_src[j] = fwd[6 * (j / 2) + 3 * (j % 2)];
  end

  assign key_wr  = cfg_we && (cfg_index == RegKeyHigh || cfg_index == RegKeyLow);
  assign mul_a   = inv_step_r[0] ? base_r : acc_r;
  assign mul_res = mul_mod(mul_a, base_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_busy_r <= 1'b0;
      inv_load_r <= 1'b0;
      inv_idx_r  <= '0;
      inv_step_r <= '0;
    end else if (key_wr) begin
      inv_busy_r <= 1'b1;
      inv_load_r <= 1'b1;
      inv_idx_r  <= '0;
      inv_step_r <= '0;
    end else if (inv_busy_r) begin
      if (inv_load_r) begin
        base_r     <= inv_src[inv_idx_r];
        acc_r      <= 16'd1;
        inv_step_r <= '0;
        inv_load_r <= 1'b0;
      end else begin
        // Even steps multiply the accumulator, odd steps square the base.
        if (inv_step_r[0]) base_r <= mul_res;
        else acc_r <= mul_res;
        if (inv_step_r == 5'(InvSteps - 1)) begin
          inv_r[inv_idx_r] <= acc_r;
          if (inv_idx_r == 5'(NInv - 1)) begin
            inv_busy_r <= 1'b0;
          end else begin
            inv_idx_r  <= inv_idx_r + 5'd1;
            inv_load_r <= 1'b1;
          end
        end else begin
          inv_step_r <= inv_step_r + 5'd1;
        end
      end
    end
  end

  // Decryption schedule: the inverses, negated forward words and the forward MA words.
  for (genvar r = 0; r <= NRounds; r++) begin : g_dec
    assign dec[6 * r]     = inv_r[2 * (NRounds - r)];
    assign dec[6 * r + 3] = inv_r[2 * (NRounds - r) + 1];
    if (r == 0 || r == NRounds) begin : g_edge
      assign dec[6 * r + 1] = 16'd0 - fwd[49 - 6 * r];
      assign dec[6 * r + 2] = 16'd0 - fwd[50 - 6 * r];
    end else begin : g_mid
      assign dec[6 * r + 1] = 16'd0 - fwd[50 - 6 * r];
      assign dec[6 * r + 2] = 16'd0 - fwd[49 - 6 * r];
    end
    if (r < NRounds) begin : g_ma
      assign dec[6 * r + 4] = fwd[46 - 6 * r];
      assign dec[6 * r + 5] = fwd[47 - 6 * r];
    end
  end

  // Round pipeline with per-stage ready, so bubbles collapse under a stall.
  stg_t st_r  [NStages];
  logic v_r   [NStages];
  logic typ_r [NStages];
  logic en    [NStages + 1];
  stg_t in_st;
  logic in_acc;

  assign en[NStages] = out_tready;
  assign in_tready   = en[0] && !inv_busy_r;
  assign in_acc      = in_tvalid && in_tready;
  assign in_st       = '{x1: in_tdata[63:48], x2: in_tdata[47:32],
                         x3: in_tdata[31:16], x4: in_tdata[15:0], t: 16'd0};

  for (genvar s = 0; s < NStages; s++) begin : g_stg
    localparam int R  = s / 3;
    localparam int Ph = s % 3;
    stg_t pv;
    logic pv_v;
    logic pv_typ;
    stg_t st_nxt;

    if (s == 0) begin : g_first
      assign pv     = in_st;
      assign pv_v   = in_acc;
      assign pv_typ = in_tuser;
    end else begin : g_next
      assign pv     = st_r[s - 1];
      assign pv_v   = v_r[s - 1];
      assign pv_typ = typ_r[s - 1];
    end

    assign en[s] = !v_r[s] || en[s + 1];

    if (s == NStages - 1) begin : g_out
      // Output transform; words stored in result order x1, x3, x2, x4.
      always_comb begin
        st_nxt    = pv;
        st_nxt.x1 = mul_mod(pv.x1, pv_typ ? dec[48] : fwd[48]);
        st_nxt.x2 = pv.x3 + (pv_typ ? dec[49] : fwd[49]);
        st_nxt.x3 = pv.x2 + (pv_typ ? dec[50] : fwd[50]);
        st_nxt.x4 = mul_mod(pv.x4, pv_typ ? dec[51] : fwd[51]);
      end
    end else if (Ph == 0) begin : g_ph0
      always_comb begin
        st_nxt    = pv;
        st_nxt.x1 = mul_mod(pv.x1, pv_typ ? dec[6 * R] : fwd[6 * R]);
        st_nxt.x2 = pv.x2 + (pv_typ ? dec[6 * R + 1] : fwd[6 * R + 1]);
        st_nxt.x3 = pv.x3 + (pv_typ ? dec[6 * R + 2] : fwd[6 * R + 2]);
        st_nxt.x4 = mul_mod(pv.x4, pv_typ ? dec[6 * R + 3] : fwd[6 * R + 3]);
      end
    end else if (Ph == 1) begin : g_ph1
      always_comb begin
        st_nxt   = pv;
        st_nxt.t = mul_mod(pv.x1 ^ pv.x3, pv_typ ? dec[6 * R + 4] : fwd[6 * R + 4]);
      end
    end else begin : g_ph2
      logic [15:0] b;
      logic [15:0] a2;
      assign b  = mul_mod((pv.x2 ^ pv.x4) + pv.t, pv_typ ? dec[6 * R + 5] : fwd[6 * R + 5]);
      assign a2 = pv.t + b;
      always_comb begin
        st_nxt    = pv;
        st_nxt.x1 = pv.x1 ^ b;
        st_nxt.x4 = pv.x4 ^ a2;
        st_nxt.x2 = b ^ pv.x3;
        st_nxt.x3 = a2 ^ pv.x2;
        st_nxt.t  = 16'd0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s]   <= pv_v;
        typ_r[s] <= pv_typ;
        st_r[s]  <= st_nxt;
      end
    end
  end

  assign out_tvalid = v_r[NStages - 1];
  assign out_tdata  = {st_r[NStages - 1].x1, st_r[NStages - 1].x2,
                       st_r[NStages - 1].x3, st_r[NStages - 1].x4};

  // No request is taken while the inverse schedule is being rebuilt.
  `IDEA_ASSERT_IMPL(a_busy_blocks, clk, rst_n, inv_busy_r, !in_tready)
  // A key write always starts the sequencer.
  `IDEA_ASSERT_NEXT(a_wr_starts, clk, rst_n, key_wr, inv_busy_r && inv_load_r)
  // The sequencer index never leaves the inverse table.
  `IDEA_ASSERT_IMPL(a_idx_range, clk, rst_n, inv_busy_r, inv_idx_r < 5'(NInv))
  // An accepted request lands in the first stage.
  `IDEA_ASSERT_NEXT(a_enter, clk, rst_n, in_acc, v_r[0])

endmodule

// File: bench/idea_block_cipher_test.sv
// ----------------------------------------------------------------------------
// IDEA block cipher testbench
// Drives encrypt and decrypt requests under several keys with random gaps on
// both channels, predicts every block in software and compares it with the
// result stream in order.
// ----------------------------------------------------------------------------
module idea_block_cipher_test
  import idea_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency   = 25;
  localparam int Watchdog  = 20000;
  localparam int NRandom   = 1200;
  localparam int MaxIdle   = 18;

  // Predictor of the cipher, with its own copy of the key schedule.
  class cipher_scoreboard;
    logic [63:0] key_hi, key_lo;
    logic [15:0] enc_keys [NKeys];
    logic [15:0] dec_keys [NKeys];
    logic [63:0] pending_blocks [$];
    int          mismatches;

    function logic [15:0] mmul(logic [15:0] a, logic [15:0] b);
      logic [33:0] x, y;
      x = (a == 0) ? 34'd65536 : 34'(a);
      y = (b == 0) ? 34'd65536 : 34'(b);
      return 16'(((x * y) % 65537));
    endfunction

    function logic [15:0] minv(logic [15:0] v);
      logic [33:0] base, acc;
      int unsigned e;
      base = (v == 0) ? 34'd65536 : 34'(v);
      acc  = 34'd1;
      e    = 65535;
      while (e != 0) begin
        if (e[0]) acc = (acc * base) % 65537;
        base = (base * base) % 65537;
        e = e >> 1;
      end
      return 16'(acc);
    endfunction

    function void write_key(logic [1:0] idx, logic [63:0] val);
      logic [63:0] h, l, nh;
      int n, k;
      if (idx == RegKeyHigh) key_hi = val;
      else if (idx == RegKeyLow) key_lo = val;
      else return;
      h = key_hi;
      l = key_lo;
      n = 0;
      while (n < NKeys) begin
        for (int p = 0; p < 8 && n < NKeys; p++) begin
          enc_keys[n] = (p < 4) ? h[48 - 16 * p +: 16] : l[48 - 16 * (p - 4) +: 16];
          n++;
        end
        nh = (h << 25) | (l >> 39);
        l  = (l << 25) | (h >> 39);
        h  = nh;
      end
      dec_keys[0] = minv(enc_keys[48]);
      dec_keys[1] = -enc_keys[49];
      dec_keys[2] = -enc_keys[50];
      dec_keys[3] = minv(enc_keys[51]);
      for (int r = 0; r < NRounds; r++) begin
        dec_keys[6 * r + 4] = enc_keys[46 - 6 * r];
        dec_keys[6 * r + 5] = enc_keys[47 - 6 * r];
        if (r + 1 < NRounds) begin
          k = 6 * (r + 1);
          dec_keys[k]     = minv(enc_keys[48 - k]);
          dec_keys[k + 1] = -enc_keys[50 - k];
          dec_keys[k + 2] = -enc_keys[49 - k];
          dec_keys[k + 3] = minv(enc_keys[51 - k]);
        end
      end
      dec_keys[48] = minv(enc_keys[0]);
      dec_keys[49] = -enc_keys[1];
      dec_keys[50] = -enc_keys[2];
      dec_keys[51] = minv(enc_keys[3]);
    endfunction

    function logic [63:0] crypt(logic decrypt, logic [63:0] blk);
      logic [15:0] ks [NKeys];
      logic [15:0] x1, x2, x3, x4, a, b, s2, s3;
      if (decrypt) ks = dec_keys;
      else ks = enc_keys;
      {x1, x2, x3, x4} = blk;
      for (int r = 0; r < NRounds; r++) begin
        x1 = mmul(x1, ks[6 * r]);
        x2 = x2 + ks[6 * r + 1];
        x3 = x3 + ks[6 * r + 2];
        x4 = mmul(x4, ks[6 * r + 3]);
        s2 = x2;
        s3 = x3;
        a  = mmul(x1 ^ x3, ks[6 * r + 4]);
        b  = mmul((x2 ^ x4) + a, ks[6 * r + 5]);
        a  = a + b;
        x1 = x1 ^ b;
        x4 = x4 ^ a;
        x2 = b ^ s3;
        x3 = a ^ s2;
      end
      return {mmul(x1, ks[48]), 16'(x3 + ks[49]), 16'(x2 + ks[50]), mmul(x4, ks[51])};
    endfunction

    function void note_request(logic decrypt, logic [63:0] blk);
      pending_blocks.push_back(crypt(decrypt, blk));
    endfunction

    function void check_block(logic [63:0] got);
      logic [63:0] want;
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_blocks.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("text_out expected %h got %h", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  cipher_scoreboard board = new();
  int  quiet_cycles;

  always #5 clk = ~clk;

  idea_block_cipher dut (.*);

  // Sample both channels at the rising edge; the watchdog counts edges on
  // which neither channel moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        board.note_request(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        board.check_block(out_tdata);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > Watchdog) begin
        $display("idea_block_cipher: mismatch");
        $finish;
      end
    end
  end

  // The receiver stalls for a random number of cycles before each result.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MaxIdle);
      if ($urandom_range(0, 4) == 0) gap = 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // One request; the gap before it is drawn per item, with bursts of none.
  // The request stays valid after acceptance until the next falling edge,
  // where it is either replaced or withdrawn.
  task automatic send_block(logic decrypt, logic [63:0] blk, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, MaxIdle);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= decrypt;
    in_tdata  <= blk;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Wait for every outstanding result, then for the pipeline to go quiet.
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending_blocks.size() != 0) @(negedge clk);
    repeat (Latency + 5) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    board.write_key(idx, val);
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  // A phase of random requests, each an encrypt or a decrypt at random; every
  // fortieth request draws whether the following ones are sent without gaps.
  task automatic random_phase(int count);
    bit burst;
    logic [63:0] blk;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) burst = $urandom_range(0, 2) == 0;
      blk = rand64();
      send_block(1'($urandom_range(0, 1)), blk, burst);
    end
  endtask

  initial begin
    logic [63:0] keys [5][2];
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Key phases: all zeros, all ones, the classic test key, then random.
    keys[0] = '{64'h0, 64'h0};
    keys[1] = '{'1, '1};
    keys[2] = '{64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008};
    keys[3] = '{rand64(), rand64()};
    keys[4] = '{rand64(), rand64()};

    for (int ph = 0; ph < 5; ph++) begin
      // Alternate the write order; an ignored index is written in between.
      if (ph % 2) begin
        write_reg(RegKeyLow, keys[ph][1]);
        write_reg(2'd3, rand64());
        write_reg(RegKeyHigh, keys[ph][0]);
      end else begin
        write_reg(RegKeyHigh, keys[ph][0]);
        write_reg(2'd2, rand64());
        write_reg(RegKeyLow, keys[ph][1]);
      end
      cfg_we <= 1'b0;
      if (ph == 2) begin
        // Directed blocks: extremes, the known vector and its ciphertext.
        send_block(1'b0, 64'h0000_0001_0002_0003, 1'b0);
        send_block(1'b1, 64'h11fb_ed2b_0198_6de5, 1'b0);
        send_block(1'b0, 64'h0, 1'b1);
        send_block(1'b1, 64'h0, 1'b1);
        send_block(1'b0, '1, 1'b1);
        send_block(1'b1, '1, 1'b0);
        send_block(1'b0, 64'h8000_0000_0000_0001, 1'b1);
        send_block(1'b1, 64'h5555_aaaa_5555_aaaa, 1'b1);
        // Sender holds off until every expected result has arrived.
        drain();
      end
      random_phase(NRandom / 5);
      drain();
    end

    if (board.mismatches == 0 && board.pending_blocks.size() == 0)
      $display("idea_block_cipher: match");
    else
      $display("idea_block_cipher: mismatch");
    $finish;
  end

endmodule
